[hw/rtl/servo_slew_ramp_pulse_mapper_macros.svh]
// assertion macros shared by the servo mapper checker
`ifndef SERVO_SLEW_RAMP_PULSE_MAPPER_MACROS_SVH
`define SERVO_SLEW_RAMP_PULSE_MAPPER_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SSRPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define SSRPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ssrpm_pkg.sv]
// types, constants and codes of the servo slew ramp pulse mapper
package ssrpm_pkg;

  localparam int JOINT_COUNT = 8;
  localparam int JOINT_IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int CH_W        = 3;
  localparam int ANGLE_W     = 11;
  localparam int COUNT_W     = 12;
  localparam int US_W        = 15;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;
  localparam logic [2:0] REG_OFFSETS  = 3'd0;
  localparam logic [2:0] REG_LIM_LOW  = 3'd1;
  localparam logic [2:0] REG_LIM_HIGH = 3'd2;
  localparam logic [2:0] REG_INVERT   = 3'd3;
  localparam logic [2:0] REG_LO_US    = 3'd4;
  localparam logic [2:0] REG_HI_US    = 3'd5;
  localparam logic [2:0] REG_PERIOD   = 3'd6;

  localparam logic [63:0]     RST_OFFSETS  = 64'h0;
  localparam logic [63:0]     RST_LIM_LOW  = 64'h0A0A_0A0A_0A0A_0A0A;
  localparam logic [63:0]     RST_LIM_HIGH = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [7:0]      RST_INVERT   = 8'h00;
  localparam logic [US_W-1:0] DEF_LO_US    = 15'd600;
  localparam logic [US_W-1:0] DEF_HI_US    = 15'd2400;
  localparam logic [7:0]      RST_PERIOD   = 8'd10;

  localparam logic [ANGLE_W-1:0] RST_ANGLE   = 11'd900;
  localparam logic [ANGLE_W-1:0] STEP_TENTHS = 11'd15;
  localparam logic [ANGLE_W-1:0] DEADBAND    = 11'd1;
  localparam logic [ANGLE_W-1:0] FULL_SCALE  = 11'd1800;

  // count = floor(sum*64/DIV_D) under SAT_SUM, 0 if sum<0, else saturated
  localparam int SUM_W       = 29;
  localparam int SUM_LOW_W   = 26;
  localparam logic [SUM_W-1:0] SAT_SUM = 29'd36000000;
  localparam logic [19:0]      DIV_D   = 20'd562500;
  localparam logic [12:0]      RECIP_M = 13'd7635;
  localparam int RECIP_SHIFT = 26;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = 1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         joint;
    logic [ANGLE_W-1:0] target_angle;
  } req_item_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [COUNT_W-1:0] pulse_count;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic [63:0]     offsets;
    logic [63:0]     lim_low;
    logic [63:0]     lim_high;
    logic [7:0]      invert;
    logic [US_W-1:0] lo_us;
    logic [US_W-1:0] hi_us;
    logic [7:0]      period;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_RAMP,
    CMD_STOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [JOINT_IDX_W-1:0] joint;
    logic [ANGLE_W-1:0]     angle;
  } cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            zero;
  } map_tag_t;

  typedef struct packed {
    map_tag_t           tag;
    logic [ANGLE_W-1:0] angle;
  } map_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RAMP,
    BK_STOP
  } back_state_t;

endpackage

[hw/rtl/servo_slew_ramp_pulse_mapper.sv]
// top level of the servo slew ramp pulse mapper
//
// req channel (valid/ready, req_item_t): set target, millisecond tick, emergency off.
// res channel (valid/ready, res_item_t): one pulse count per joint, last marks
// the final item of a run. APB-style port, 64-bit data, register i at 8*i.
// A set target yields no item; the back end takes it without leaving its idle state.
// A tick that reaches the ramp period sweeps all joints, one per cycle while
// the pulse pipeline is not stalled; every joint that moves yields one item.
// Emergency off yields JOINT_COUNT items with count zero.
// The first item of a run passes the queue, the back end's sweep and the pulse
// pipeline, then at most one per cycle; the pulse pipeline is six register stages deep.
// A two-entry command queue sits between front and back, so items are taken
// while a sweep runs. When res_valid is high and res_ready is low, the pulse
// pipeline and sweep freeze, the queue fills and req_ready drops. Reset sets
// all angles to 900 tenths, the ramp timer to zero and the registers to their
// defaults; no item is in flight afterwards.
module servo_slew_ramp_pulse_mapper import ssrpm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_item_t          req_data,
  output logic               res_valid,
  input  logic               res_ready,
  output res_item_t          res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       reg_wr;

  logic     q_push;
  cmd_t     q_push_cmd;
  logic     q_full;
  logic     q_pop;
  logic     q_avail;
  cmd_t     q_head;
  logic     iss_valid;
  map_req_t iss_req;
  logic     iss_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offsets  <= RST_OFFSETS;
      cfg.lim_low  <= RST_LIM_LOW;
      cfg.lim_high <= RST_LIM_HIGH;
      cfg.invert   <= RST_INVERT;
      cfg.lo_us    <= DEF_LO_US;
      cfg.hi_us    <= DEF_HI_US;
      cfg.period   <= RST_PERIOD;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_OFFSETS:  cfg.offsets  <= pwdata;
        REG_LIM_LOW:  cfg.lim_low  <= pwdata;
        REG_LIM_HIGH: cfg.lim_high <= pwdata;
        REG_INVERT:   cfg.invert   <= pwdata[7:0];
        REG_LO_US:    cfg.lo_us    <= pwdata[US_W-1:0];
        REG_HI_US:    cfg.hi_us    <= pwdata[US_W-1:0];
        REG_PERIOD:   cfg.period   <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSETS:  prdata = cfg.offsets;
      REG_LIM_LOW:  prdata = cfg.lim_low;
      REG_LIM_HIGH: prdata = cfg.lim_high;
      REG_INVERT:   prdata = PDATA_W'(cfg.invert);
      REG_LO_US:    prdata = PDATA_W'(cfg.lo_us);
      REG_HI_US:    prdata = PDATA_W'(cfg.hi_us);
      REG_PERIOD:   prdata = PDATA_W'(cfg.period);
      default:      prdata = '0;
    endcase
  end

  ssrpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .period    (cfg.period),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (q_push_cmd)
  );

  ssrpm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  ssrpm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .pop       (q_pop),
    .iss_valid (iss_valid),
    .iss_req   (iss_req),
    .iss_ready (iss_ready)
  );

  ssrpm_mapper u_mapper (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (iss_valid),
    .req       (iss_req),
    .req_ready (iss_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res_data)
  );

endmodule

[hw/rtl/ssrpm_cmd_queue.sv]
// two-entry command queue between the front and the back
module ssrpm_cmd_queue import ssrpm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;

  assign full  = (count == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
  assign avail = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hw/rtl/ssrpm_front.sv]
// front end: takes items, keeps the ramp timer and queues commands
module ssrpm_front import ssrpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_item_t  req_data,
  input  logic [7:0] period,
  input  logic       q_full,
  output logic       push,
  output cmd_t       push_cmd
);

  logic [7:0] ms_since_ramp;
  logic [7:0] ms_since_ramp_next;
  logic [7:0] ms_inc;
  logic       accept;

  assign req_ready = !q_full;
  assign accept    = req_valid && !q_full;
  assign ms_inc    = (ms_since_ramp == 8'hFF) ? ms_since_ramp : ms_since_ramp + 8'd1;

  always_comb begin
    push               = 1'b0;
    push_cmd.op        = CMD_SET;
    push_cmd.joint     = req_data.joint[JOINT_IDX_W-1:0];
    push_cmd.angle     = req_data.target_angle;
    ms_since_ramp_next = ms_since_ramp;
    if (accept) begin
      case (req_data.req_type)
        REQ_SET: begin
          push = (req_data.joint < 4'(JOINT_COUNT));
        end
        REQ_TICK: begin
          if (ms_inc >= period) begin
            push               = 1'b1;
            push_cmd.op        = CMD_RAMP;
            ms_since_ramp_next = '0;
          end else begin
            ms_since_ramp_next = ms_inc;
          end
        end
        REQ_STOP: begin
          push        = 1'b1;
          push_cmd.op = CMD_STOP;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_since_ramp <= '0;
    end else begin
      ms_since_ramp <= ms_since_ramp_next;
    end
  end

endmodule

[hw/rtl/ssrpm_back.sv]
// back end: joint angles and the sweep sequencer for ramp and stop
module ssrpm_back import ssrpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_avail,
  input  cmd_t     q_head,
  output logic     pop,
  output logic     iss_valid,
  output map_req_t iss_req,
  input  logic     iss_ready
);

  localparam logic [JOINT_IDX_W-1:0] LAST_IDX = JOINT_IDX_W'(JOINT_COUNT - 1);

  back_state_t              state;
  back_state_t              state_next;
  logic [JOINT_IDX_W-1:0]   idx;
  logic [JOINT_IDX_W-1:0]   idx_next;
  logic [JOINT_COUNT-1:0]   mask;
  logic [JOINT_COUNT-1:0]   move_mask;
  logic [ANGLE_W-1:0]       target_angles [JOINT_COUNT];
  logic [ANGLE_W-1:0]       current_angles [JOINT_COUNT];
  logic [ANGLE_W-1:0]       step_angle;
  logic                     cur_write;

  function automatic logic [ANGLE_W-1:0] ramp_next(input logic [ANGLE_W-1:0] c,
                                                   input logic [ANGLE_W-1:0] t);
    logic [ANGLE_W-1:0] d;
    logic [ANGLE_W-1:0] r;
    if (c < t) begin
      d = t - c;
      r = (d <= STEP_TENTHS) ? t : c + STEP_TENTHS;
    end else begin
      d = c - t;
      r = (d <= STEP_TENTHS) ? t : c - STEP_TENTHS;
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < JOINT_COUNT; i++) begin
      if (current_angles[i] > target_angles[i]) begin
        move_mask[i] = (current_angles[i] - target_angles[i]) > DEADBAND;
      end else begin
        move_mask[i] = (target_angles[i] - current_angles[i]) > DEADBAND;
      end
    end
  end

  assign step_angle = ramp_next(current_angles[idx], target_angles[idx]);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pop               = 1'b0;
    iss_valid         = 1'b0;
    cur_write         = 1'b0;
    iss_req.tag.ch    = CH_W'(idx);
    iss_req.tag.last  = 1'b0;
    iss_req.tag.zero  = 1'b0;
    iss_req.angle     = step_angle;
    case (state)
      BK_IDLE: begin
        idx_next = '0;
        if (q_avail) begin
          pop = 1'b1;
          case (q_head.op)
            CMD_RAMP: state_next = BK_RAMP;
            CMD_STOP: state_next = BK_STOP;
            default:  state_next = BK_IDLE;
          endcase
        end
      end
      BK_RAMP: begin
        iss_req.tag.last = ((mask >> idx) == JOINT_COUNT'(1));
        if (iss_ready) begin
          iss_valid = mask[idx];
          cur_write = mask[idx];
          if (idx == LAST_IDX) begin
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      BK_STOP: begin
        iss_req.tag.zero = 1'b1;
        iss_req.tag.last = (idx == LAST_IDX);
        if (iss_ready) begin
          iss_valid = 1'b1;
          if (idx == LAST_IDX) begin
            state_next = BK_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
      mask  <= '0;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        target_angles[i]  <= RST_ANGLE;
        current_angles[i] <= RST_ANGLE;
      end
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (pop && (q_head.op == CMD_RAMP)) begin
        mask <= move_mask;
      end
      if (pop && (q_head.op == CMD_SET)) begin
        target_angles[q_head.joint] <= q_head.angle;
      end
      if (cur_write) begin
        current_angles[idx] <= step_angle;
      end
    end
  end

endmodule

[hw/rtl/ssrpm_mapper.sv]
// angle to pulse-count pipeline with the output register
module ssrpm_mapper import ssrpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      req_valid,
  input  map_req_t  req,
  output logic      req_ready,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  logic adv;

  logic     v1, v2, v3, v4, v5;
  map_req_t r1;
  map_tag_t t2, t3, t4, t5;

  logic [7:0]         off_b;
  logic [7:0]         low_b;
  logic [7:0]         high_b;
  logic signed [12:0] off_x10;
  logic signed [12:0] a_sum;
  logic signed [12:0] a_inv;
  logic signed [12:0] lo_lim;
  logic signed [12:0] hi_lim;
  logic signed [12:0] a_cl;
  logic [11:0]        a2;

  logic [US_W-1:0]        lo_us;
  logic [US_W-1:0]        hi_us;
  logic signed [15:0]     us_diff;
  logic signed [SUM_W-1:0] prod3;
  logic [SUM_LOW_W-1:0]   base3;

  logic signed [SUM_W-1:0] sum4;

  logic [SUM_LOW_W+12:0]  recip_prod;
  logic [COUNT_W-1:0]     q5;
  logic [SUM_LOW_W-1:0]   s5;
  logic                   neg5;
  logic                   sat5;

  logic [31:0]            x6;
  logic [31:0]            qd6;
  logic [32:0]            rem6;
  logic [COUNT_W-1:0]     q6;
  logic [COUNT_W-1:0]     count6;

  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  // offset, inversion and joint limits
  assign off_b   = cfg.offsets[{r1.tag.ch, 3'b000} +: 8];
  assign low_b   = cfg.lim_low[{r1.tag.ch, 3'b000} +: 8];
  assign high_b  = cfg.lim_high[{r1.tag.ch, 3'b000} +: 8];
  assign off_x10 = ({{5{off_b[7]}}, off_b} <<< 3) + ({{5{off_b[7]}}, off_b} <<< 1);
  assign a_sum   = $signed({2'b00, r1.angle}) + off_x10;
  assign a_inv   = cfg.invert[r1.tag.ch] ? $signed({2'b00, FULL_SCALE}) - a_sum : a_sum;
  assign lo_lim  = $signed(13'({5'b0, low_b}) * 13'd10);
  assign hi_lim  = $signed(13'({5'b0, high_b}) * 13'd10);

  always_comb begin
    if (a_inv < lo_lim) begin
      a_cl = lo_lim;
    end else if (a_inv > hi_lim) begin
      a_cl = hi_lim;
    end else begin
      a_cl = a_inv;
    end
  end

  // pulse span product and base
  assign lo_us   = (cfg.lo_us == '0) ? DEF_LO_US : cfg.lo_us;
  assign hi_us   = (cfg.hi_us == '0) ? DEF_HI_US : cfg.hi_us;
  assign us_diff = $signed({1'b0, hi_us}) - $signed({1'b0, lo_us});

  // reciprocal estimate, low by at most one
  assign recip_prod = sum4[SUM_LOW_W-1:0] * RECIP_M;

  // one correction step
  assign x6     = {s5, 6'b000000};
  assign qd6    = 32'(q5) * 32'(DIV_D);
  assign rem6   = {1'b0, x6} - {1'b0, qd6};
  assign q6     = (rem6 >= 33'(DIV_D)) ? q5 + 1'b1 : q5;
  assign count6 = (t5.zero || neg5) ? '0 : (sat5 ? '1 : q6);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v1        <= req_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1    <= req;
      t2    <= r1.tag;
      a2    <= a_cl[11:0];
      t3    <= t2;
      prod3 <= SUM_W'($signed({1'b0, a2})) * SUM_W'(us_diff);
      base3 <= SUM_LOW_W'(lo_us) * SUM_LOW_W'(FULL_SCALE);
      t4    <= t3;
      sum4  <= $signed({3'b000, base3}) + prod3;
      t5    <= t4;
      q5    <= recip_prod[RECIP_SHIFT+COUNT_W-1:RECIP_SHIFT];
      s5    <= sum4[SUM_LOW_W-1:0];
      neg5  <= sum4[SUM_W-1];
      sat5  <= !sum4[SUM_W-1] && (sum4 >= $signed(SAT_SUM));
      res.channel     <= t5.ch;
      res.pulse_count <= count6;
      res.last        <= t5.last;
    end
  end

endmodule

[hw/rtl/ssrpm_checker.sv]
// port-level checks for the servo slew ramp pulse mapper
`include "servo_slew_ramp_pulse_mapper_macros.svh"

module ssrpm_checker import ssrpm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_ready,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_data,
  input logic      psel,
  input logic      penable,
  input logic      pready
);

  `SSRPM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data), "res item changed while stalled")
  `SSRPM_ASSERT_NOW(a_reset_clean, $past(rst), !res_valid && req_ready, "item in flight after reset")
  `SSRPM_ASSERT_NOW(a_top_joint_last, res_valid && (res_data.channel == CH_W'(JOINT_COUNT - 1)), res_data.last, "highest joint not marked last")
  `SSRPM_ASSERT_NOW(a_apb_ready, psel && penable, pready, "apb access without pready")

endmodule

bind servo_slew_ramp_pulse_mapper ssrpm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data),
  .psel      (psel),
  .penable   (penable),
  .pready    (pready)
);
